// File: rtl/pogp_pkg.sv
// shared constants, codes and control types of the predicted obstacle grid painter
`timescale 1ns / 1ps
package pogp_pkg;

    localparam int GRID_WIDTH_DEF  = 128;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int MAX_LAYERS_DEF  = 16;
    localparam int HALF_WINDOW_DEF = 5;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int ACC_W = 40;
    localparam int NUM_W = ACC_W + 2;
    localparam int DEN_W = 25;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAYERS_IN_USE = 3'd4;

    localparam logic [15:0] CELL_SIZE_RST     = 16'd77;
    localparam logic [15:0] TIME_STEP_RST     = 16'd128;
    localparam logic [4:0]  LAYERS_IN_USE_RST = 5'd10;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic div_start;
        logic win_load;
        logic paint_row;
        logic next_layer;
        logic rd_issue;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       n_zero;
        logic       clr_last;
        logic       div_done;
        logic       win_empty;
        logic       paint_last;
        logic       layer_last;
    } sts_t;

endpackage

// File: rtl/pogp_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pogp_div
    import pogp_pkg::*;
#(
    parameter int NW = NUM_W,
    parameter int DW = DEN_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]   num_reg, num_next;
    logic [NW-1:0]   quot_reg, quot_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW:0]     trial;
    logic            ge;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quot_next = {quot_reg[NW-2:0], ge};
            num_next  = {num_reg[NW-2:0], 1'b0};
            cnt_next  = cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/pogp_datapath.sv
// datapath: configuration, prediction accumulators, dividers, window and layer store
`timescale 1ns / 1ps
module pogp_datapath
    import pogp_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW    = $clog2(GRID_WIDTH);
    localparam int RW    = $clog2(GRID_HEIGHT);
    localparam int DEPTH = MAX_LAYERS * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_LAYERS + 1);
    localparam int CIW   = NUM_W + 2;
    localparam logic signed [CIW-1:0] HWS   = CIW'(HALF_WINDOW);
    localparam logic signed [CIW-1:0] XMAXS = CIW'(GRID_WIDTH - 1);
    localparam logic signed [CIW-1:0] YMAXS = CIW'(GRID_HEIGHT - 1);

    logic [15:0] cell_size_reg;
    logic [23:0] origin_x_reg;
    logic [23:0] origin_y_reg;
    logic [15:0] time_step_reg;
    logic [4:0]  layers_in_use_reg;

    logic signed [23:0] pos_x, pos_y;
    logic signed [15:0] vel_x, vel_y;
    logic [3:0]         layer;
    logic [6:0]         cell_col;
    logic [5:0]         cell_row;

    assign pos_x    = s_axis_tdata[23:0];
    assign pos_y    = s_axis_tdata[47:24];
    assign vel_x    = s_axis_tdata[63:48];
    assign vel_y    = s_axis_tdata[79:64];
    assign layer    = s_axis_tdata[83:80];
    assign cell_col = s_axis_tdata[90:84];
    assign cell_row = s_axis_tdata[96:91];

    logic [15:0]          cs_eff;
    logic [DEN_W-1:0]     den;
    logic [31:0]          lu_w;
    logic [KW-1:0]        n_act;
    logic signed [24:0]   diff_x, diff_y;
    logic signed [32:0]   prod_x, prod_y;
    logic [31:0]          layer_w, col_w, row_w;

    assign cs_eff = (cell_size_reg == 16'd0) ? 16'd1 : cell_size_reg;
    assign den    = {cs_eff, 9'b0};
    assign lu_w   = 32'(layers_in_use_reg);
    assign n_act  = (lu_w > 32'(MAX_LAYERS)) ? KW'(MAX_LAYERS) : KW'(lu_w);
    assign diff_x = {pos_x[23], pos_x} - {origin_x_reg[23], origin_x_reg};
    assign diff_y = {pos_y[23], pos_y} - {origin_y_reg[23], origin_y_reg};
    assign prod_x = $signed({1'b0, time_step_reg}) * vel_x;
    assign prod_y = $signed({1'b0, time_step_reg}) * vel_y;
    assign layer_w = 32'(layer);
    assign col_w   = 32'(cell_col);
    assign row_w   = 32'(cell_row);

    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg, step_x_reg, step_y_reg;
    logic [KW-1:0]           k_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic                    rd_ok_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic [CW-1:0]           col_reg;
    logic [CW-1:0]           i0_reg, i1_reg;
    logic [RW-1:0]           row_reg, j1_reg;
    logic                    empty_reg;
    logic                    occupied_reg;
    logic [GRID_WIDTH-1:0]   rdata_reg;

    // divider operands: 2|N| + D over 2D
    logic [ACC_W-1:0] mag_x, mag_y;
    logic [NUM_W-1:0] num_x, num_y, quot_x, quot_y;
    logic             done_x, done_y;

    assign mag_x = acc_x_reg[ACC_W-1] ? ACC_W'(-acc_x_reg) : ACC_W'(acc_x_reg);
    assign mag_y = acc_y_reg[ACC_W-1] ? ACC_W'(-acc_y_reg) : ACC_W'(acc_y_reg);
    assign num_x = {1'b0, mag_x, 1'b0} + NUM_W'({cs_eff, 8'b0});
    assign num_y = {1'b0, mag_y, 1'b0} + NUM_W'({cs_eff, 8'b0});

    pogp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_x),
        .den   (den),
        .done  (done_x),
        .quot  (quot_x)
    );

    pogp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_y),
        .den   (den),
        .done  (done_y),
        .quot  (quot_y)
    );

    // window bounds around the rounded cell
    logic signed [CIW-1:0] ci, cj, lo_x, hi_x, lo_y, hi_y;
    logic [CW-1:0]         i0_c, i1_c;
    logic [RW-1:0]         j0_c, j1_c;
    logic                  empty_c;

    always_comb
    begin
        ci   = acc_x_reg[ACC_W-1] ? -$signed({2'b0, quot_x}) : $signed({2'b0, quot_x});
        cj   = acc_y_reg[ACC_W-1] ? -$signed({2'b0, quot_y}) : $signed({2'b0, quot_y});
        lo_x = ci - HWS;
        hi_x = ci + HWS;
        lo_y = cj - HWS;
        hi_y = cj + HWS;
        empty_c = hi_x[CIW-1] || (lo_x > XMAXS) || hi_y[CIW-1] || (lo_y > YMAXS);
        i0_c = lo_x[CIW-1] ? '0 : lo_x[CW-1:0];
        i1_c = (hi_x > XMAXS) ? XMAXS[CW-1:0] : hi_x[CW-1:0];
        j0_c = lo_y[CIW-1] ? '0 : lo_y[RW-1:0];
        j1_c = (hi_y > YMAXS) ? YMAXS[RW-1:0] : hi_y[RW-1:0];
    end

    logic [GRID_WIDTH-1:0] mask;
    logic [AW-1:0]         paint_addr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [GRID_WIDTH-1:0] wmask;
    logic                  wbit;

    always_comb
    begin
        for (int b = 0; b < GRID_WIDTH; b++)
        begin
            mask[b] = (CW'(b) >= i0_reg) && (CW'(b) <= i1_reg);
        end
    end

    assign paint_addr = AW'(32'(k_reg) * GRID_HEIGHT + 32'(row_reg));
    assign we    = cmd.clr_step || cmd.paint_row;
    assign waddr = cmd.clr_step ? clr_addr_reg : paint_addr;
    assign wmask = cmd.clr_step ? '1 : mask;
    assign wbit  = !cmd.clr_step;

    logic [GRID_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < GRID_WIDTH; b++)
            begin
                if (wmask[b])
                begin
                    mem[waddr][b] <= wbit;
                end
            end
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg     <= CELL_SIZE_RST;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            time_step_reg     <= TIME_STEP_RST;
            layers_in_use_reg <= LAYERS_IN_USE_RST;
            k_reg             <= '0;
            clr_addr_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CELL_SIZE:     cell_size_reg     <= cfg_data[15:0];
                    REG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                    REG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                    REG_TIME_STEP:     time_step_reg     <= cfg_data[15:0];
                    REG_LAYERS_IN_USE: layers_in_use_reg <= cfg_data[4:0];
                    default:           ;
                endcase
            end
            if (cmd.load_item)
            begin
                k_reg        <= '0;
                clr_addr_reg <= '0;
            end
            else
            begin
                if (cmd.next_layer)
                begin
                    k_reg <= k_reg + KW'(1);
                end
                if (cmd.clr_step)
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            acc_x_reg   <= {{(ACC_W - 33){diff_x[24]}}, diff_x, 8'b0};
            acc_y_reg   <= {{(ACC_W - 33){diff_y[24]}}, diff_y, 8'b0};
            step_x_reg  <= ACC_W'(prod_x);
            step_y_reg  <= ACC_W'(prod_y);
            rd_ok_reg   <= (layer_w < 32'(n_act)) && (layer_w < 32'(MAX_LAYERS))
                           && (col_w < 32'(GRID_WIDTH)) && (row_w < 32'(GRID_HEIGHT));
            rd_addr_reg <= AW'(layer_w * GRID_HEIGHT + row_w);
            col_reg     <= col_w[CW-1:0];
        end
        else if (cmd.next_layer)
        begin
            acc_x_reg <= acc_x_reg + step_x_reg;
            acc_y_reg <= acc_y_reg + step_y_reg;
        end
        if (cmd.win_load)
        begin
            i0_reg    <= i0_c;
            i1_reg    <= i1_c;
            row_reg   <= j0_c;
            j1_reg    <= j1_c;
            empty_reg <= empty_c;
        end
        else if (cmd.paint_row)
        begin
            row_reg <= row_reg + RW'(1);
        end
        if (cmd.out_load)
        begin
            occupied_reg <= rd_ok_reg && rdata_reg[col_reg];
        end
    end

    assign sts.mode       = s_axis_tuser;
    assign sts.n_zero     = (n_act == '0);
    assign sts.clr_last   = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.div_done   = done_x && done_y;
    assign sts.win_empty  = empty_reg;
    assign sts.paint_last = (row_reg == j1_reg);
    assign sts.layer_last = ((k_reg + KW'(1)) == n_act);

    assign m_axis_tdata = {{(OUT_TDATA_W - 1){1'b0}}, occupied_reg};

endmodule

// File: rtl/pogp_ctrl.sv
// controller state machine sequencing clear, add and read items
`timescale 1ns / 1ps
module pogp_ctrl
    import pogp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_WAIT  = 4'd3;
    localparam logic [3:0] ST_WIN   = 4'd4;
    localparam logic [3:0] ST_PAINT = 4'd5;
    localparam logic [3:0] ST_NEXT  = 4'd6;
    localparam logic [3:0] ST_RD    = 4'd7;
    localparam logic [3:0] ST_RESP  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign accept = s_axis_tvalid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    priority if (sts.mode == MODE_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (sts.mode == MODE_ADD)
                    begin
                        state_next = sts.n_zero ? ST_IDLE : ST_DIV;
                    end
                    else if (sts.mode == MODE_READ)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                cmd.win_load = 1'b1;
                state_next   = ST_PAINT;
            end
            ST_PAINT:
            begin
                cmd.paint_row = !sts.win_empty;
                if (sts.win_empty || sts.paint_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                cmd.next_layer = 1'b1;
                state_next     = sts.layer_last ? ST_IDLE : ST_DIV;
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result beat overwritten before taken");

    a_div_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider finished too early");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESP)
        else $error("result beat without read item");

endmodule

// File: rtl/predicted_obstacle_grid_painter_core.sv
// top level of the predicted obstacle grid painter
`timescale 1ns / 1ps
// input beats on s_axis: tuser carries the item kind (clear, add agent, read cell),
// tdata the agent position, velocity and the cell to read; one beat per item.
// result beats on m_axis: one beat per read item, occupied flag in tdata bit 0.
// the user writes cell size, origin, time step and layer count over the cfg channel
// only while idle; the block itself does not enforce it.
// clear item: one store row per cycle over MAX_LAYERS*GRID_HEIGHT rows (1024 here).
// add item: per active layer the x and y dividers run in parallel, then the window
// bounds are loaded, the window is painted row by row and the next layer follows.
// read item: ST_RD reads the store row into a register, then ST_RESP loads the
// occupied flag into the output register, which raises m_axis_tvalid.
// after reset all MAX_LAYERS*GRID_HEIGHT store rows are cleared row by row,
// with s_axis_tready low; cfg writes are taken throughout.
// a read result waits in the output register while m_axis_tready is low; the next
// clear or add item is still taken, a further read waits for the register to free.
module predicted_obstacle_grid_painter_core
    import pogp_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, layer, cell_col, cell_row, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // occupied, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pogp_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    pogp_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .MAX_LAYERS  (MAX_LAYERS),
        .HALF_WINDOW (HALF_WINDOW)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule
